// ----- design/indexed_deque_list_engine_top_assert.svh -----
// assertion macros for the deque list engine, used by idl_seq
// depends on nothing; included by idl_seq, which checks its own logic
`ifndef INDEXED_DEQUE_LIST_ENGINE_TOP_ASSERT_SVH
`define INDEXED_DEQUE_LIST_ENGINE_TOP_ASSERT_SVH

// property holds on every clock edge outside reset
`define IDL_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication checked on the next edge
`define IDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/idl_pkg.sv -----
// package for the indexed deque list engine
// shared op and status codes; no dependencies
`timescale 1ns / 1ps
package idl_pkg;
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT_AT  = 3'd4,
        OP_REMOVE_AT  = 3'd5,
        OP_READ_AT    = 3'd6,
        OP_FIND       = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    localparam int OP_W = 3;
    localparam int IN_VALUE_W = 32;
    localparam int POS_IN_W = 5;
    localparam int POS_OUT_W = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_OUT_W = 5;
endpackage

// ----- design/idl_store.sv -----
// link and value store of the deque list engine: one write port, registered reads
// depends on idl_pkg; next links get a clearing sweep after reset
`timescale 1ns / 1ps
module idl_store
    import idl_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [$clog2(CAPACITY)-1:0] i_rd_addr,
    output logic [VALUE_WIDTH-1:0]      o_rd_value,
    output logic [$clog2(CAPACITY)-1:0] o_rd_next,
    output logic [$clog2(CAPACITY)-1:0] o_rd_prev,
    input  logic                        i_wr_val_en,
    input  logic                        i_wr_next_en,
    input  logic                        i_wr_prev_en,
    input  logic [$clog2(CAPACITY)-1:0] i_wr_addr,
    input  logic [VALUE_WIDTH-1:0]      i_wr_value,
    input  logic [$clog2(CAPACITY)-1:0] i_wr_link,
    output logic                        o_init_done
);
    localparam int AW = $clog2(CAPACITY);
    localparam int LAST = CAPACITY - 1;

    logic [VALUE_WIDTH-1:0] r_values [CAPACITY];
    logic [AW-1:0]          r_next   [CAPACITY];
    logic [AW-1:0]          r_prev   [CAPACITY];
    logic [AW-1:0]          r_clr_addr;
    logic                   r_init_done;
    logic [AW-1:0]          w_clr_link;

    // entry k links to k+1, the last wraps to zero
    assign w_clr_link = (r_clr_addr == AW'(LAST)) ? '0 : r_clr_addr + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_init_done <= 1'b0;
        end else if (!r_init_done) begin
            r_clr_addr <= w_clr_link;
            if (r_clr_addr == AW'(LAST)) begin
                r_init_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_init_done) begin
            r_next[r_clr_addr] <= w_clr_link;
        end else if (i_wr_next_en) begin
            r_next[i_wr_addr] <= i_wr_link;
        end
        if (i_wr_val_en) begin
            r_values[i_wr_addr] <= i_wr_value;
        end
        if (i_wr_prev_en) begin
            r_prev[i_wr_addr] <= i_wr_link;
        end
        o_rd_value <= r_values[i_rd_addr];
        o_rd_next  <= r_next[i_rd_addr];
        o_rd_prev  <= r_prev[i_rd_addr];
    end

    assign o_init_done = r_init_done;
endmodule

// ----- design/idl_seq.sv -----
// sequencer of the deque list engine: walks links one at a time and relinks
// depends on idl_pkg, idl_store and the assertion macro header
`timescale 1ns / 1ps
`include "indexed_deque_list_engine_top_assert.svh"
module idl_seq
    import idl_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  t_op                    i_op,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [POS_IN_W-1:0]    i_pos,
    output logic                   o_ready,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [POS_OUT_W-1:0]   o_pos,
    output t_status                o_status,
    output logic [COUNT_OUT_W-1:0] o_count
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CHECK, S_WALK_RD, S_WALK_WAIT, S_WALK,
        S_INS_PRED_WAIT, S_INS_LINK, S_REM_WAIT, S_REM_LINK, S_REM_FREE, S_DONE
    } t_state;

    t_state                 r_state;
    t_op                    r_op;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [CW-1:0]          r_pos;
    logic [CW-1:0]          r_k;
    logic [AW-1:0]          r_cur;
    logic [AW-1:0]          r_new;
    logic [AW-1:0]          r_pred;
    logic [AW-1:0]          r_succ;
    logic [1:0]             r_step;
    logic [AW-1:0]          r_front, r_back, r_free;
    logic [CW-1:0]          r_count;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic [POS_OUT_W-1:0]   r_out_pos;
    t_status                r_out_status;
    logic                   r_done;

    logic [AW-1:0]          s_rd_addr, s_wr_addr, s_wr_link;
    logic                   s_wr_val, s_wr_next, s_wr_prev;
    logic [VALUE_WIDTH-1:0] w_rd_value;
    logic [AW-1:0]          w_rd_next, w_rd_prev;
    logic                   w_init_done;
    logic                   w_ins, w_full, w_empty;
    logic [CW-1:0]          w_pos_in;

    idl_store #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd_addr(s_rd_addr),
        .o_rd_value(w_rd_value), .o_rd_next(w_rd_next), .o_rd_prev(w_rd_prev),
        .i_wr_val_en(s_wr_val), .i_wr_next_en(s_wr_next), .i_wr_prev_en(s_wr_prev),
        .i_wr_addr(s_wr_addr), .i_wr_value(r_value), .i_wr_link(s_wr_link),
        .o_init_done(w_init_done)
    );

    assign w_ins   = (r_op == OP_PUSH_FRONT) || (r_op == OP_PUSH_BACK) ||
                     (r_op == OP_INSERT_AT);
    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_pos_in = (CW > POS_IN_W) ? CW'(i_pos) : CW'(i_pos);

    // store port usage per state
    always_comb begin
        s_rd_addr = r_cur;
        s_wr_addr = r_cur;
        s_wr_link = r_cur;
        s_wr_val  = 1'b0;
        s_wr_next = 1'b0;
        s_wr_prev = 1'b0;
        unique case (r_state)
            S_CHECK: s_rd_addr = r_free;
            S_INS_LINK: begin
                // four link writes, one per step, with the value write in the first step
                unique case (r_step)
                    2'd0: begin
                        s_wr_addr = r_new; s_wr_val = 1'b1;
                        s_wr_next = 1'b1; s_wr_link = w_empty ? r_new : r_succ;
                    end
                    2'd1: begin
                        s_wr_addr = r_new; s_wr_prev = 1'b1;
                        s_wr_link = w_empty ? r_new : r_pred;
                    end
                    2'd2: begin
                        s_wr_addr = r_pred; s_wr_next = !w_empty; s_wr_link = r_new;
                    end
                    default: begin
                        s_wr_addr = r_succ; s_wr_prev = !w_empty; s_wr_link = r_new;
                    end
                endcase
            end
            S_REM_LINK: begin
                if (r_step == 2'd0) begin
                    s_wr_addr = r_pred; s_wr_next = 1'b1; s_wr_link = r_succ;
                end else begin
                    s_wr_addr = r_succ; s_wr_prev = 1'b1; s_wr_link = r_pred;
                end
            end
            S_REM_FREE: begin
                s_wr_addr = r_cur; s_wr_next = 1'b1; s_wr_link = r_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_front      <= '0;
            r_back       <= '0;
            r_free       <= '0;
            r_count      <= '0;
            r_done       <= 1'b0;
            r_step       <= '0;
            r_k          <= '0;
            r_out_status <= ST_OK;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_INIT: if (w_init_done) r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_start) begin
                        r_op    <= i_op;
                        r_value <= i_value;
                        r_pos   <= w_pos_in;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_out_value  <= '0;
                    r_out_pos    <= '0;
                    r_out_status <= ST_OK;
                    r_k          <= '0;
                    r_cur        <= r_front;
                    r_step       <= '0;
                    r_new        <= r_free;
                    unique case (r_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
                            if (w_full) begin
                                r_out_status <= ST_FULL; r_state <= S_DONE;
                            end else if (r_op == OP_INSERT_AT && r_pos > r_count) begin
                                r_out_status <= ST_RANGE; r_state <= S_DONE;
                            end else begin
                                if (r_op == OP_PUSH_FRONT) r_pos <= '0;
                                if (r_op == OP_PUSH_BACK) r_pos <= r_count;
                                r_state <= S_WALK_RD;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (w_empty) begin
                                r_out_status <= ST_EMPTY; r_state <= S_DONE;
                            end else begin
                                r_pos   <= (r_op == OP_POP_FRONT) ? '0 : r_count - CW'(1);
                                r_state <= S_WALK_RD;
                            end
                        end
                        OP_REMOVE_AT, OP_READ_AT: begin
                            if (w_empty) begin
                                r_out_status <= ST_EMPTY; r_state <= S_DONE;
                            end else if (r_pos >= r_count) begin
                                r_out_status <= ST_RANGE; r_state <= S_DONE;
                            end else begin
                                r_state <= S_WALK_RD;
                            end
                        end
                        default: begin
                            if (w_empty) begin
                                r_out_status <= ST_EMPTY; r_state <= S_DONE;
                            end else begin
                                r_pos   <= r_count;
                                r_state <= S_WALK_RD;
                            end
                        end
                    endcase
                end
                S_WALK_RD: begin
                    // free chain head read in S_CHECK arrives now
                    if (w_ins) r_free <= w_rd_next;
                    r_state <= S_WALK_WAIT;
                end
                S_WALK_WAIT: r_state <= S_WALK;
                S_WALK: begin
                    // r_cur data is on the read port; one link per pass
                    if (r_op == OP_FIND && w_rd_value == r_value) begin
                        r_out_pos <= POS_OUT_W'(r_k);
                        r_state   <= S_DONE;
                    end else if (r_op == OP_FIND && r_k + CW'(1) == r_pos) begin
                        r_out_status <= ST_NOTFOUND;
                        r_state      <= S_DONE;
                    end else if (r_op != OP_FIND && (r_k == r_pos ||
                                 (w_ins && r_pos == r_count))) begin
                        r_succ <= r_cur;
                        r_pred <= w_rd_prev;
                        if (w_ins) begin
                            r_state <= S_INS_LINK;
                        end else begin
                            r_out_value <= (r_op == OP_READ_AT) ? '0 : w_rd_value;
                            if (r_op == OP_READ_AT) r_out_value <= w_rd_value;
                            r_succ  <= w_rd_next;
                            r_state <= (r_op == OP_READ_AT) ? S_DONE :
                                       (r_count == CW'(1)) ? S_REM_FREE : S_REM_LINK;
                        end
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_cur   <= w_rd_next;
                        r_state <= S_WALK_WAIT;
                    end
                end
                S_INS_LINK: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        if (w_empty) begin
                            r_front <= r_new;
                            r_back  <= r_new;
                        end else begin
                            if (r_pos == '0) r_front <= r_new;
                            if (r_pos == r_count) r_back <= r_new;
                        end
                        r_count <= r_count + CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_REM_LINK: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd1) begin
                        if (r_pos == '0) r_front <= r_succ;
                        if (r_pos + CW'(1) == r_count) r_back <= r_pred;
                        r_state <= S_REM_FREE;
                    end
                end
                S_REM_FREE: begin
                    r_free  <= r_cur;
                    r_count <= r_count - CW'(1);
                    r_state <= S_DONE;
                end
                S_REM_WAIT: r_state <= S_DONE;
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_done   = r_done;
    assign o_value  = r_out_value;
    assign o_pos    = r_out_pos;
    assign o_status = r_out_status;
    assign o_count  = COUNT_OUT_W'(r_count);

    `IDL_ASSERT_CLK(a_count_range, r_count <= CW'(CAPACITY), "count beyond capacity")
    `IDL_ASSERT_NEXT(a_start_leaves_idle, r_state == S_IDLE && i_start,
        r_state == S_CHECK, "accepted item did not start")
    `IDL_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "done held for two cycles")
    `IDL_ASSERT_CLK(a_walk_bound, r_k <= CW'(CAPACITY), "walk ran past capacity")
endmodule

// ----- design/indexed_deque_list_engine_top.sv -----
// Indexed deque list engine: a list of up to CAPACITY values kept as a
// circular doubly linked store with a free chain. After reset a sweep sets
// up the free chain before the first item is taken. One item at a time.
// An item is checked and then reaches the front entry; indexed requests
// and find then walk one link at a time (up to the list length), as each
// link read goes through the registered store read. An insert writes its
// value and links through the single store write port; a remove relinks
// its neighbours, when any remain, and frees its entry. The result goes
// through the done state to the output register; a request refused by its
// checks skips the walk. A result waits in the output register; the next
// item is taken once it has been delivered.
// depends on idl_pkg and idl_seq
`timescale 1ns / 1ps
module indexed_deque_list_engine_top
    import idl_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // operation[2:0], item_value[34:3], position_in[39:35]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // value_out[31:0], position_out[35:32], status[38:36],
                                        // entry_count[43:39]
);
    logic                   w_ready, w_done;
    logic [VALUE_WIDTH-1:0] w_value;
    logic [POS_OUT_W-1:0]   w_pos;
    t_status                w_status;
    logic [COUNT_OUT_W-1:0] w_count;
    logic                   r_out_valid;
    logic [47:0]            r_out_data;
    logic [IN_VALUE_W-1:0]  w_in_value;
    logic [63:0]            w_value_ext;

    assign w_in_value  = s_axis_tdata[34:3];
    assign w_value_ext = 64'(w_value);

    idl_seq #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid && s_axis_tready),
        .i_op(t_op'(s_axis_tdata[2:0])),
        .i_value(VALUE_WIDTH'(64'(w_in_value))),
        .i_pos(s_axis_tdata[39:35]),
        .o_ready(w_ready), .o_done(w_done), .o_value(w_value), .o_pos(w_pos),
        .o_status(w_status), .o_count(w_count)
    );

    // the result of the last item must reach the output register first
    assign s_axis_tready = w_ready && !r_out_valid && !w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_done) begin
            r_out_data <= {4'd0, w_count, w_status, w_pos, w_value_ext[31:0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
endmodule
